// ===== rtl/rsa_modular_exponentiation_core_macros.svh =====
// Assertion macros shared by the RSA exponentiation core.
// Each macro takes a label, the condition terms and a message string.
`ifndef RSA_MODULAR_EXPONENTIATION_CORE_MACROS_SVH
`define RSA_MODULAR_EXPONENTIATION_CORE_MACROS_SVH

// Same-cycle implication, checked out of reset
`define RSA_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset
`define RSA_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/rsa_mexp_pkg.sv =====
package rsa_mexp_pkg;

    // Port widths fixed by the word format
    localparam int DATA_W    = 64;
    localparam int CFG_IDX_W = 2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MODULUS     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PUBLIC_EXP  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PRIVATE_EXP = 2'd2;

    // Operation codes on the cmd port
    localparam logic CMD_ENCRYPT = 1'b0;
    localparam logic CMD_DECRYPT = 1'b1;

    // Reset values of the configuration registers
    localparam logic [DATA_W-1:0] MODULUS_RESET = 64'd2;
    localparam logic [DATA_W-1:0] EXP_RESET     = 64'd1;

    // Commands from controller to datapath
    typedef struct packed {
        logic load;          // capture operand, exponent and modulus
        logic reduce_step;   // one restoring remainder step
        logic reduce_last;   // copy final remainder into base
        logic mul_acc_load;  // start product acc * base
        logic mul_base_load; // start product base * base
        logic mul_step;      // one shift-and-add step
        logic acc_write;     // product done, write acc
        logic base_write;    // product done, write base
        logic exp_shift;     // drop the scanned exponent bit
        logic emit;          // present the result word
    } dp_cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic n_small;       // modulus below two
        logic ex_zero;       // exponent exhausted
        logic ex_lsb;        // current exponent bit
        logic ex_next_zero;  // exponent exhausted after the shift
        logic mb_zero;       // multiplier operand exhausted
    } dp_status_t;

endpackage

// ===== rtl/rsa_mexp_datapath.sv =====
module rsa_mexp_datapath #(
    parameter int WIDTH = 64
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  rsa_mexp_pkg::dp_cmd_t             ctl,
    output rsa_mexp_pkg::dp_status_t          status,
    input  logic                              cmd,
    input  logic [rsa_mexp_pkg::DATA_W-1:0]   value,
    input  logic [rsa_mexp_pkg::DATA_W-1:0]   modulus,
    input  logic [rsa_mexp_pkg::DATA_W-1:0]   public_exponent,
    input  logic [rsa_mexp_pkg::DATA_W-1:0]   private_exponent,
    output logic [rsa_mexp_pkg::DATA_W-1:0]   result,
    output logic                              done
);
    import rsa_mexp_pkg::*;

    logic [WIDTH-1:0] n_reg;
    logic [WIDTH-1:0] ex_reg;
    logic [WIDTH-1:0] val_reg;
    logic [WIDTH-1:0] rem_reg;
    logic [WIDTH-1:0] base_reg;
    logic [WIDTH-1:0] acc_reg;
    logic [WIDTH-1:0] ma_reg;
    logic [WIDTH-1:0] mb_reg;
    logic [WIDTH-1:0] mp_reg;
    logic [WIDTH-1:0] result_reg;
    logic             done_reg;

    logic [WIDTH:0]   n_ext;
    logic [WIDTH:0]   trial;
    logic [WIDTH:0]   trial_diff;
    logic [WIDTH-1:0] rem_next;
    logic [WIDTH:0]   add_sum;
    logic [WIDTH:0]   add_diff;
    logic [WIDTH-1:0] add_mod;
    logic [WIDTH:0]   dbl_sum;
    logic [WIDTH:0]   dbl_diff;
    logic [WIDTH-1:0] dbl_mod;

    assign n_ext = {1'b0, n_reg};

    // Shift the next operand bit into the remainder and subtract if it fits
    always_comb
    begin
        trial      = {rem_reg, val_reg[WIDTH-1]};
        trial_diff = trial - n_ext;
        rem_next   = (trial >= n_ext) ? trial_diff[WIDTH-1:0] : trial[WIDTH-1:0];
    end

    // Modular add of the partial product and the operand, and modular doubling of the operand, carry kept
    always_comb
    begin
        add_sum  = {1'b0, mp_reg} + {1'b0, ma_reg};
        add_diff = add_sum - n_ext;
        add_mod  = (add_sum >= n_ext) ? add_diff[WIDTH-1:0] : add_sum[WIDTH-1:0];
        dbl_sum  = {ma_reg, 1'b0};
        dbl_diff = dbl_sum - n_ext;
        dbl_mod  = (dbl_sum >= n_ext) ? dbl_diff[WIDTH-1:0] : dbl_sum[WIDTH-1:0];
    end

    // Operand, exponent and product registers
    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            n_reg   <= modulus[WIDTH-1:0];
            ex_reg  <= (cmd == CMD_DECRYPT) ? private_exponent[WIDTH-1:0]
                                            : public_exponent[WIDTH-1:0];
            val_reg <= value[WIDTH-1:0];
            rem_reg <= '0;
            acc_reg <= WIDTH'(1);
        end
        if (ctl.reduce_step)
        begin
            rem_reg <= rem_next;
            val_reg <= {val_reg[WIDTH-2:0], 1'b0};
        end
        if (ctl.reduce_last)
        begin
            base_reg <= rem_next;
        end
        if (ctl.mul_acc_load)
        begin
            ma_reg <= acc_reg;
            mb_reg <= base_reg;
            mp_reg <= '0;
        end
        if (ctl.mul_base_load)
        begin
            ma_reg <= base_reg;
            mb_reg <= base_reg;
            mp_reg <= '0;
        end
        if (ctl.mul_step)
        begin
            if (mb_reg[0])
            begin
                mp_reg <= add_mod;
            end
            ma_reg <= dbl_mod;
            mb_reg <= {1'b0, mb_reg[WIDTH-1:1]};
        end
        if (ctl.acc_write)
        begin
            acc_reg <= mp_reg;
        end
        if (ctl.base_write)
        begin
            base_reg <= mp_reg;
        end
        if (ctl.exp_shift)
        begin
            ex_reg <= {1'b0, ex_reg[WIDTH-1:1]};
        end
        if (ctl.emit)
        begin
            result_reg <= status.n_small ? '0 : acc_reg;
        end
    end

    // Pulse the result strobe for one cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= ctl.emit;
        end
    end

    assign status.n_small      = (n_reg[WIDTH-1:1] == '0);
    assign status.ex_zero      = (ex_reg == '0);
    assign status.ex_lsb       = ex_reg[0];
    assign status.ex_next_zero = (ex_reg[WIDTH-1:1] == '0);
    assign status.mb_zero      = (mb_reg == '0);

    assign result = DATA_W'(result_reg);
    assign done   = done_reg;

endmodule

// ===== rtl/rsa_mexp_ctrl.sv =====
module rsa_mexp_ctrl #(
    parameter int WIDTH = 64
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    output logic                      busy,
    input  rsa_mexp_pkg::dp_status_t  status,
    output rsa_mexp_pkg::dp_cmd_t     ctl
);
    import rsa_mexp_pkg::*;

    localparam int CNT_W = $clog2(WIDTH);

    typedef enum logic [2:0] {
        S_IDLE,
        S_REDUCE,
        S_CHECK,
        S_MUL_ACC,
        S_SHIFT,
        S_MUL_BASE
    } state_t;

    state_t           state_reg;
    state_t           state_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic             busy_reg;

    // Sequence reduction, then square-and-multiply from the exponent LSB
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        ctl        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    ctl.load   = 1'b1;
                    cnt_next   = '0;
                    state_next = S_REDUCE;
                end
            end
            S_REDUCE:
            begin
                ctl.reduce_step = 1'b1;
                cnt_next        = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(WIDTH - 1))
                begin
                    ctl.reduce_last = 1'b1;
                    state_next      = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (status.n_small || status.ex_zero)
                begin
                    ctl.emit   = 1'b1;
                    state_next = S_IDLE;
                end
                else if (status.ex_lsb)
                begin
                    ctl.mul_acc_load = 1'b1;
                    state_next       = S_MUL_ACC;
                end
                else
                begin
                    state_next = S_SHIFT;
                end
            end
            S_MUL_ACC:
            begin
                if (status.mb_zero)
                begin
                    ctl.acc_write = 1'b1;
                    state_next    = S_SHIFT;
                end
                else
                begin
                    ctl.mul_step = 1'b1;
                end
            end
            S_SHIFT:
            begin
                ctl.exp_shift = 1'b1;
                if (status.ex_next_zero)
                begin
                    ctl.emit   = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    ctl.mul_base_load = 1'b1;
                    state_next        = S_MUL_BASE;
                end
            end
            S_MUL_BASE:
            begin
                if (status.mb_zero)
                begin
                    ctl.base_write = 1'b1;
                    state_next     = S_CHECK;
                end
                else
                begin
                    ctl.mul_step = 1'b1;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold state, step counter and busy flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            busy_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            busy_reg  <= (state_next != S_IDLE);
        end
    end

    assign busy = busy_reg;

endmodule

// ===== rtl/rsa_modular_exponentiation_core.sv =====
// Sequence: WIDTH reduction steps, then per exponent bit a check state, an optional product
// into the accumulator, a shift state and a squaring of the base (the last bit skips its
// squaring); each product runs shift-and-add steps until its multiplier is exhausted.
// Throughput: one word at a time, set by the bit-per-cycle multiplier; busy falls with done.
// Reset (rst_n, async, active low) idles the controller and loads modulus 2, exponents 1.
// The result is shown for one cycle with done; the receiver cannot stall it.
`include "rsa_modular_exponentiation_core_macros.svh"

module rsa_modular_exponentiation_core #(
    parameter int WIDTH = 64
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic                                 cmd,
    input  logic [rsa_mexp_pkg::DATA_W-1:0]      value,
    output logic [rsa_mexp_pkg::DATA_W-1:0]      result,
    output logic                                 done,
    input  logic                                 cfg_write,
    input  logic [rsa_mexp_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [rsa_mexp_pkg::DATA_W-1:0]      cfg_data
);
    import rsa_mexp_pkg::*;

    logic [DATA_W-1:0] modulus_reg;
    logic [DATA_W-1:0] pub_exp_reg;
    logic [DATA_W-1:0] priv_exp_reg;

    dp_cmd_t    ctl;
    dp_status_t status;

    // Write configuration registers; drop writes to unused indexes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            modulus_reg  <= MODULUS_RESET;
            pub_exp_reg  <= EXP_RESET;
            priv_exp_reg <= EXP_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_MODULUS:     modulus_reg  <= cfg_data;
                REG_PUBLIC_EXP:  pub_exp_reg  <= cfg_data;
                REG_PRIVATE_EXP: priv_exp_reg <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    rsa_mexp_ctrl #(
        .WIDTH (WIDTH)
    ) u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .status (status),
        .ctl    (ctl)
    );

    rsa_mexp_datapath #(
        .WIDTH (WIDTH)
    ) u_datapath (
        .clk              (clk),
        .rst_n            (rst_n),
        .ctl              (ctl),
        .status           (status),
        .cmd              (cmd),
        .value            (value),
        .modulus          (modulus_reg),
        .public_exponent  (pub_exp_reg),
        .private_exponent (priv_exp_reg),
        .result           (result),
        .done             (done)
    );

    // An accepted word keeps the core busy in the next cycle
    `RSA_ASSERT_NXT(a_accept_busy, start && !busy, busy, "accepted word did not raise busy")
    // The result word leaves only as the core goes idle
    `RSA_ASSERT_IMP(a_done_idle, done, !busy, "done while busy")
    // One strobe per word: reduction alone spans many cycles
    `RSA_ASSERT_NXT(a_done_pulse, done, !done, "done held for more than one cycle")

endmodule

// ===== sim/rsa_modular_exponentiation_core_tb.sv =====
module rsa_modular_exponentiation_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rsa_mexp_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE    = 2'd3;
    localparam logic [DATA_W-1:0]    ONES         = '1;
    localparam int                   NUM_DIRECTED = 22;
    localparam int                   NUM_PHASES   = 6;
    localparam int                   PHASE_WORDS  = 13;

    typedef struct {
        logic              reload;
        logic [DATA_W-1:0] modulus;
        logic [DATA_W-1:0] pub_exp;
        logic [DATA_W-1:0] priv_exp;
        logic              op;
        logic [DATA_W-1:0] word;
        logic              known;
        logic [DATA_W-1:0] want;
    } directed_word_t;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 start     = 1'b0;
    logic                 cmd       = CMD_ENCRYPT;
    logic [DATA_W-1:0]    value     = '0;
    logic                 cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = REG_MODULUS;
    logic [DATA_W-1:0]    cfg_data  = '0;
    logic                 busy;
    logic                 done;
    logic [DATA_W-1:0]    result;

    // Shadow copy of the key registers
    logic [DATA_W-1:0] key_modulus  = MODULUS_RESET;
    logic [DATA_W-1:0] key_public   = EXP_RESET;
    logic [DATA_W-1:0] key_private  = EXP_RESET;

    logic [DATA_W-1:0] expected_results [$];
    directed_word_t    directed_words [NUM_DIRECTED];
    int unsigned       burst_left      = 0;
    int unsigned       errors          = 0;
    int unsigned       words_checked   = 0;
    int unsigned       encrypt_count   = 0;
    int unsigned       decrypt_count   = 0;
    int unsigned       settings_loaded = 0;

    rsa_modular_exponentiation_core u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .cmd       (cmd),
        .value     (value),
        .result    (result),
        .done      (done),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #6 clk = ~clk;

    // (a + b) mod n with the carry kept, a and b below n
    function automatic logic [DATA_W-1:0] add_mod_n(input logic [DATA_W-1:0] a,
                                                    input logic [DATA_W-1:0] b,
                                                    input logic [DATA_W-1:0] n);
        logic [DATA_W:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        if (sum >= {1'b0, n})
            sum = sum - {1'b0, n};
        return sum[DATA_W-1:0];
    endfunction

    // (a * b) mod n by shift-and-add
    function automatic logic [DATA_W-1:0] mul_mod_n(input logic [DATA_W-1:0] a,
                                                    input logic [DATA_W-1:0] b,
                                                    input logic [DATA_W-1:0] n);
        logic [DATA_W-1:0] acc;
        logic [DATA_W-1:0] addend;
        logic [DATA_W-1:0] mult;
        acc    = '0;
        addend = a;
        mult   = b;
        while (mult != '0)
        begin
            if (mult[0])
                acc = add_mod_n(acc, addend, n);
            addend = add_mod_n(addend, addend, n);
            mult   = mult >> 1;
        end
        return acc;
    endfunction

    // Word raised to the selected exponent modulo the current modulus
    function automatic logic [DATA_W-1:0] expected_power(input logic op,
                                                         input logic [DATA_W-1:0] word);
        logic [DATA_W-1:0] n;
        logic [DATA_W-1:0] ex;
        logic [DATA_W-1:0] base;
        logic [DATA_W-1:0] acc;
        n  = key_modulus;
        ex = (op == CMD_DECRYPT) ? key_private : key_public;
        if (n < 2)
            return '0;
        acc  = 64'd1;
        base = word % n;
        while (ex != '0)
        begin
            if (ex[0])
                acc = mul_mod_n(acc, base, n);
            ex   = ex >> 1;
            base = mul_mod_n(base, base, n);
        end
        return acc;
    endfunction

    function automatic logic [DATA_W-1:0] rand_word();
        return {$urandom, $urandom};
    endfunction

    // Mostly short exponents; full width and the extremes now and then
    function automatic logic [DATA_W-1:0] rand_exponent();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return ONES;
            2, 3, 4: return {48'd0, 16'($urandom)};
            5:       return 64'($urandom_range(1, 3));
            6, 7:    return {32'd0, $urandom};
            default: return rand_word();
        endcase
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] data);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge clk);
        cfg_write <= 1'b0;
        case (idx)
            REG_MODULUS:     key_modulus = data;
            REG_PUBLIC_EXP:  key_public  = data;
            REG_PRIVATE_EXP: key_private = data;
            default:         ;
        endcase
    endtask

    // Hold off the sender until every outstanding word has come back
    task automatic drain_results();
        @(negedge clk);
        start <= 1'b0;
        while (expected_results.size() != 0 || busy)
            @(negedge clk);
    endtask

    // Load a key set while idle; the spare index must not disturb it
    task automatic load_keys(input logic [DATA_W-1:0] n,
                             input logic [DATA_W-1:0] e,
                             input logic [DATA_W-1:0] d);
        drain_results();
        write_reg(REG_MODULUS, n);
        write_reg(REG_PUBLIC_EXP, e);
        write_reg(REG_PRIVATE_EXP, d);
        write_reg(REG_SPARE, rand_word());
        settings_loaded++;
    endtask

    // Issue one word after a random gap and record its expected result
    task automatic send_word(input logic op, input logic [DATA_W-1:0] word,
                             input logic known, input logic [DATA_W-1:0] want);
        int unsigned gap;
        if (burst_left != 0)
        begin
            gap = 0;
            burst_left--;
        end
        else if ($urandom_range(0, 7) == 0)
        begin
            gap        = 0;
            burst_left = $urandom_range(3, 8);
        end
        else
        begin
            gap = $urandom_range(0, 14);
        end
        @(negedge clk);
        if (gap != 0)
        begin
            start <= 1'b0;
            while (busy)
                @(negedge clk);
            repeat (gap) @(negedge clk);
        end
        start <= 1'b1;
        cmd   <= op;
        value <= word;
        do
            @(posedge clk);
        while (busy);
        expected_results.push_back(known ? want : expected_power(op, word));
        if (op == CMD_DECRYPT)
            decrypt_count++;
        else
            encrypt_count++;
    endtask

    // Compare each result word with the oldest expectation
    always @(posedge clk)
    begin : check_result
        logic [DATA_W-1:0] oldest;
        if (rst_n && done)
        begin
            if (expected_results.size() == 0)
            begin
                $display("%0t: result %h with no word outstanding", $time, result);
                errors++;
            end
            else
            begin
                oldest = expected_results.pop_front();
                words_checked++;
                if (result !== oldest)
                begin
                    $display("%0t: result mismatch: expected %h, actual %h",
                             $time, oldest, result);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        logic [DATA_W-1:0] n;
        logic [DATA_W-1:0] word;
        logic              op;

        // reload, modulus, public, private, cmd, word, known, want
        directed_words = '{
            '{1'b0, 64'd0, 64'd0, 64'd0, CMD_ENCRYPT, 64'd0, 1'b1, 64'd0},
            '{1'b0, 64'd0, 64'd0, 64'd0, CMD_ENCRYPT, ONES, 1'b1, 64'd1},
            '{1'b0, 64'd0, 64'd0, 64'd0, CMD_DECRYPT, 64'd2, 1'b1, 64'd0},
            '{1'b0, 64'd0, 64'd0, 64'd0, CMD_DECRYPT, 64'd3, 1'b1, 64'd1},
            '{1'b1, 64'd0, 64'd5, 64'd7, CMD_ENCRYPT, 64'd12345, 1'b1, 64'd0},
            '{1'b1, 64'd1, 64'd5, 64'd7, CMD_DECRYPT, 64'd12345, 1'b1, 64'd0},
            '{1'b1, 64'd3233, 64'd17, 64'd2753, CMD_ENCRYPT, 64'd65, 1'b1, 64'd2790},
            '{1'b0, 64'd0, 64'd0, 64'd0, CMD_DECRYPT, 64'd2790, 1'b1, 64'd65},
            '{1'b0, 64'd0, 64'd0, 64'd0, CMD_ENCRYPT, 64'd3233, 1'b1, 64'd0},
            '{1'b0, 64'd0, 64'd0, 64'd0, CMD_ENCRYPT, 64'd3299, 1'b0, 64'd0},
            '{1'b1, ONES, 64'd0, ONES, CMD_ENCRYPT, 64'd0, 1'b1, 64'd1},
            '{1'b0, 64'd0, 64'd0, 64'd0, CMD_ENCRYPT, ONES, 1'b1, 64'd1},
            '{1'b0, 64'd0, 64'd0, 64'd0, CMD_DECRYPT, 64'hFFFF_FFFF_FFFF_FFFE,
              1'b1, 64'hFFFF_FFFF_FFFF_FFFE},
            '{1'b0, 64'd0, 64'd0, 64'd0, CMD_DECRYPT, 64'd2, 1'b0, 64'd0},
            '{1'b1, 64'h8000_0000_0000_0001, 64'd65537, 64'd0, CMD_ENCRYPT,
              64'h7FFF_FFFF_FFFF_FFFF, 1'b0, 64'd0},
            '{1'b0, 64'd0, 64'd0, 64'd0, CMD_DECRYPT, 64'd5, 1'b1, 64'd1},
            '{1'b0, 64'd0, 64'd0, 64'd0, CMD_ENCRYPT, ONES, 1'b0, 64'd0},
            '{1'b1, 64'd2, 64'd0, ONES, CMD_ENCRYPT, 64'd1, 1'b1, 64'd1},
            '{1'b0, 64'd0, 64'd0, 64'd0, CMD_DECRYPT, 64'd1, 1'b1, 64'd1},
            '{1'b0, 64'd0, 64'd0, 64'd0, CMD_DECRYPT, 64'hFFFF_FFFF_FFFF_FFFE,
              1'b1, 64'd0},
            '{1'b1, 64'hFFFF_FFFF_FFFF_FFC5, 64'hFFFF_FFFF_FFFF_FFC4, 64'd1,
              CMD_ENCRYPT, 64'd3, 1'b0, 64'd0},
            '{1'b0, 64'd0, 64'd0, 64'd0, CMD_DECRYPT, ONES, 1'b1, 64'h3A}
        };

        // Hold reset, then release on a falling edge
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;

        // Walk the directed table, starting from the reset keys
        foreach (directed_words[i])
        begin
            if (directed_words[i].reload)
                load_keys(directed_words[i].modulus, directed_words[i].pub_exp,
                          directed_words[i].priv_exp);
            send_word(directed_words[i].op, directed_words[i].word,
                      directed_words[i].known, directed_words[i].want);
        end

        // Random key sets, each followed by a run of random words
        for (int phase = 0; phase < NUM_PHASES; phase++)
        begin
            case ($urandom_range(0, 9))
                0:       n = 64'($urandom_range(0, 1));
                1:       n = 64'($urandom_range(2, 3));
                2, 3, 4: n = {48'd0, 16'($urandom) | 16'h8000};
                5, 6:    n = {32'd0, $urandom | 32'h8000_0000};
                7:       n = rand_word() | {1'b1, 63'd0};
                8:       n = ONES;
                default: n = rand_word();
            endcase
            load_keys(n, rand_exponent(), rand_exponent());
            for (int k = 0; k < PHASE_WORDS; k++)
            begin
                case ($urandom_range(0, 9))
                    6, 7:    word = (n >= 2) ? rand_word() % n : rand_word();
                    8:       word = '0;
                    9:       word = ONES;
                    default: word = rand_word();
                endcase
                op = $urandom_range(0, 1) ? CMD_DECRYPT : CMD_ENCRYPT;
                send_word(op, word, 1'b0, '0);
                if ($urandom_range(0, 15) == 0)
                    drain_results();
            end
        end

        // Let the last results come back, then a few quiet cycles
        drain_results();
        repeat (16) @(negedge clk);

        $display("Checked %0d words (%0d encrypt, %0d decrypt) over %0d key loads,",
                 words_checked, encrypt_count, decrypt_count, settings_loaded);
        $display("covering reset keys, moduli below two, all-ones keys and zero exponents.");
        if (errors == 0)
            $display("rsa_modular_exponentiation_core_tb: PASS");
        else
            $display("rsa_modular_exponentiation_core_tb: FAIL");
        $finish;
    end

    // Watchdog
    initial
    begin
        #60_000_000;
        $display("Timeout with %0d words outstanding", expected_results.size());
        $display("rsa_modular_exponentiation_core_tb: FAIL");
        $finish;
    end

endmodule
